// ===== rtl/smi_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the saturation helper function of the small matrix inverse core.
package smi_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int EW     = 32;
    localparam int PW     = 2 * EW;
    localparam int AW     = PW + 1;
    localparam int DW     = PW + EW + 2;
    localparam int VW     = DW + EW + 1;
    localparam int QW     = 32;
    localparam int NE     = 9;
    localparam int CFG_W  = 2;
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [CFG_W-1:0] DIM_TWO   = 2'd2;
    localparam logic [CFG_W-1:0] DIM_THREE = 2'd3;

    typedef logic [3:0] t_idx;
    typedef logic signed [EW-1:0] t_elem;

    // Operand indexes of the two products that form each adjugate entry.
    localparam t_idx PL [NE] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam t_idx PR [NE] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam t_idx ML [NE] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam t_idx MR [NE] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

    typedef struct packed {
        logic             two;
        t_elem [NE-1:0]   a;
    } t_front_word;

    typedef struct packed {
        logic                   sing;
        logic [EW-1:0]          det;
        logic [NE-1:0]          neg;
        logic [NE-1:0]          ovf;
        logic [NE-1:0][VW-1:0]  rem;
        logic [NE-1:0][QW-1:0]  q;
        logic [VW-1:0]          dmag;
    } t_div_word;

    typedef struct packed {
        logic                   sing;
        logic [EW-1:0]          det;
        logic [NE-1:0][EW-1:0]  inv;
    } t_result;

    function automatic logic [EW-1:0] sat32(input logic neg, input logic big,
                                            input logic [EW-1:0] m);
        logic [EW-1:0] r;
        if (!neg) begin
            r = (big || m[EW-1]) ? {1'b0, {(EW-1){1'b1}}} : m;
        end else begin
            r = (big || m > {1'b1, {(EW-1){1'b0}}}) ? {1'b1, {(EW-1){1'b0}}} : (~m + 1'b1);
        end
        return r;
    endfunction

endpackage

// ===== rtl/small_matrix_inverse_core.sv =====
`timescale 1ns / 1ps
// Top level of the small matrix inverse core.
//
// The input channel takes one matrix word of nine signed fixed point elements
// when i_valid is high and o_stall is low. The output channel presents the
// inverse, the determinant and the singular flag with o_valid; the word is
// taken when i_stall is low. The configuration channel writes the matrix
// dimension (2 or 3; any other code means 3) and is always ready.
// A word enters a four-entry queue, then runs through a six-stage adjugate
// and determinant pipeline and a 33-stage restoring divider (an overflow
// check, then one quotient bit per stage for all nine entries), and lands in
// the output register. One word is accepted every cycle while o_stall is low.
// When the receiver stalls with a word waiting, the whole back pipeline holds,
// the queue fills and o_stall rises once it is full.
// Synchronous reset empties the queue and the pipeline and sets the
// dimension to 3.
module small_matrix_inverse_core #(
    parameter int FRAC_BITS = smi_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [smi_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [smi_pkg::EW-1:0] i_a00,
    input  logic signed [smi_pkg::EW-1:0] i_a01,
    input  logic signed [smi_pkg::EW-1:0] i_a02,
    input  logic signed [smi_pkg::EW-1:0] i_a10,
    input  logic signed [smi_pkg::EW-1:0] i_a11,
    input  logic signed [smi_pkg::EW-1:0] i_a12,
    input  logic signed [smi_pkg::EW-1:0] i_a20,
    input  logic signed [smi_pkg::EW-1:0] i_a21,
    input  logic signed [smi_pkg::EW-1:0] i_a22,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [smi_pkg::EW-1:0] o_inv00,
    output logic signed [smi_pkg::EW-1:0] o_inv01,
    output logic signed [smi_pkg::EW-1:0] o_inv02,
    output logic signed [smi_pkg::EW-1:0] o_inv10,
    output logic signed [smi_pkg::EW-1:0] o_inv11,
    output logic signed [smi_pkg::EW-1:0] o_inv12,
    output logic signed [smi_pkg::EW-1:0] o_inv20,
    output logic signed [smi_pkg::EW-1:0] o_inv21,
    output logic signed [smi_pkg::EW-1:0] o_inv22,
    output logic signed [smi_pkg::EW-1:0] o_det,
    output logic                         o_singular
);
    import smi_pkg::*;

    t_elem [NE-1:0] w_a;
    logic           q_valid;
    t_front_word    q_word;
    logic           en;
    logic           adj_valid;
    t_div_word      adj_word;
    logic           div_valid;
    t_result        div_res;
    logic           r_out_valid;
    t_result        r_res;

    assign w_a[0] = i_a00;
    assign w_a[1] = i_a01;
    assign w_a[2] = i_a02;
    assign w_a[3] = i_a10;
    assign w_a[4] = i_a11;
    assign w_a[5] = i_a12;
    assign w_a[6] = i_a20;
    assign w_a[7] = i_a21;
    assign w_a[8] = i_a22;

    assign en = !r_out_valid || !i_stall;

    smi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_a         (w_a),
        .o_q_valid   (q_valid),
        .o_q_word    (q_word),
        .i_q_pop     (en)
    );

    smi_adjugate #(
        .FRAC_BITS (FRAC_BITS)
    ) u_adjugate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (q_valid),
        .i_word  (q_word),
        .o_valid (adj_valid),
        .o_word  (adj_word)
    );

    smi_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (adj_valid),
        .i_word  (adj_word),
        .o_valid (div_valid),
        .o_res   (div_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= div_res;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_inv00    = r_res.inv[0];
    assign o_inv01    = r_res.inv[1];
    assign o_inv02    = r_res.inv[2];
    assign o_inv10    = r_res.inv[3];
    assign o_inv11    = r_res.inv[4];
    assign o_inv12    = r_res.inv[5];
    assign o_inv20    = r_res.inv[6];
    assign o_inv21    = r_res.inv[7];
    assign o_inv22    = r_res.inv[8];
    assign o_det      = r_res.det;
    assign o_singular = r_res.sing;

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> o_det == '0 && o_inv00 == '0 && o_inv11 == '0
                                  && o_inv22 == '0)
        else $error("singular word carries nonzero results");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("reset did not empty the block");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_det) && $stable(o_inv00))
        else $error("stalled output word changed");

endmodule

// ===== rtl/smi_front.sv =====
`timescale 1ns / 1ps
// Front part: dimension register, input acceptance and the word queue.
module smi_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [smi_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  smi_pkg::t_elem [smi_pkg::NE-1:0] i_a,
    output logic                           o_q_valid,
    output smi_pkg::t_front_word           o_q_word,
    input  logic                           i_q_pop
);
    import smi_pkg::*;

    logic [CFG_W-1:0] r_dim;
    t_front_word      r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr;
    logic [QAW:0]     r_count;
    logic             push;
    logic             pop;
    t_front_word      w_in;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_count == (QAW+1)'(QDEPTH));
    assign o_q_valid   = (r_count != '0);
    assign o_q_word    = r_mem[r_rd_ptr];
    assign push        = i_valid && !o_stall;
    assign pop         = i_q_pop && o_q_valid;
    assign w_in.two    = (r_dim == DIM_TWO);
    assign w_in.a      = i_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= DIM_THREE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_dim <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= w_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/smi_adjugate.sv =====
`timescale 1ns / 1ps
// Back part, first half: cofactor products, adjugate, determinant and magnitudes.
module smi_adjugate #(
    parameter int FRAC_BITS = smi_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  smi_pkg::t_front_word  i_word,
    output logic                  o_valid,
    output smi_pkg::t_div_word    o_word
);
    import smi_pkg::*;

    logic [5:0] r_v;

    logic                    r1_two;
    t_elem [2:0]             r1_a;
    t_elem                   r1_e [4];
    logic signed [PW-1:0]    r1_pp [NE];
    logic signed [PW-1:0]    r1_pm [NE];

    logic signed [AW-1:0]    n2_adj [NE];
    logic                    r2_two;
    t_elem [2:0]             r2_a;
    logic signed [AW-1:0]    r2_adj [NE];

    logic                    r3_two;
    logic signed [AW-1:0]    r3_adj [NE];
    logic signed [AW-1:0]    r3_lo [3];
    logic signed [AW-1:0]    r3_hi [3];

    logic                    r4_two;
    logic signed [AW-1:0]    r4_adj [NE];
    logic signed [DW-1:0]    r4_t [3];

    logic                    r5_two;
    logic signed [AW-1:0]    r5_adj [NE];
    logic signed [DW-1:0]    r5_det;

    t_div_word               r6_word;
    t_div_word               n6_word;
    logic                    dneg;
    logic [DW-1:0]           dmag;
    logic [DW-1:0]           dshv;
    logic [AW-1:0]           amag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_comb begin
        for (int k = 0; k < NE; k++) begin
            n2_adj[k] = AW'(r1_pp[k]) - AW'(r1_pm[k]);
            if (r1_two && k != NE - 1) begin
                n2_adj[k] = '0;
            end
        end
        if (r1_two) begin
            n2_adj[0] = AW'(r1_e[3]);
            n2_adj[1] = -AW'(r1_e[1]);
            n2_adj[3] = -AW'(r1_e[2]);
            n2_adj[4] = AW'(r1_e[0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_two <= i_word.two;
            r1_a   <= i_word.a[2:0];
            r1_e[0] <= i_word.a[0];
            r1_e[1] <= i_word.a[1];
            r1_e[2] <= i_word.a[3];
            r1_e[3] <= i_word.a[4];
            for (int k = 0; k < NE; k++) begin
                r1_pp[k] <= $signed(i_word.a[PL[k]]) * $signed(i_word.a[PR[k]]);
                r1_pm[k] <= $signed(i_word.a[ML[k]]) * $signed(i_word.a[MR[k]]);
            end

            r2_two <= r1_two;
            r2_a   <= r1_a;
            r2_adj <= n2_adj;

            r3_two <= r2_two;
            r3_adj <= r2_adj;
            for (int j = 0; j < 3; j++) begin
                r3_lo[j] <= $signed({1'b0, r2_adj[3*j][EW-1:0]}) * $signed(r2_a[j]);
                r3_hi[j] <= $signed(r2_adj[3*j][AW-1:EW]) * $signed(r2_a[j]);
            end

            r4_two <= r3_two;
            r4_adj <= r3_adj;
            for (int j = 0; j < 3; j++) begin
                r4_t[j] <= (DW'(r3_hi[j]) <<< EW) + DW'(r3_lo[j]);
            end

            r5_two <= r4_two;
            for (int k = 0; k < NE; k++) begin
                r5_adj[k] <= (r4_two && k == NE - 1) ? '0 : r4_adj[k];
            end
            r5_det <= r4_two ? DW'(r4_adj[NE-1]) : (r4_t[0] + r4_t[1] + r4_t[2]);

            r6_word <= n6_word;
        end
    end

    always_comb begin
        n6_word = '0;
        amag    = '0;
        dneg    = r5_det[DW-1];
        dmag    = dneg ? DW'(-r5_det) : DW'(r5_det);
        dshv    = r5_two ? (dmag >> FRAC_BITS) : (dmag >> (2 * FRAC_BITS));
        n6_word.sing = (r5_det == '0);
        n6_word.dmag = VW'(dmag);
        n6_word.det  = sat32(dneg, |dshv[DW-1:EW], dshv[EW-1:0]);
        for (int k = 0; k < NE; k++) begin
            amag = r5_adj[k][AW-1] ? AW'(-r5_adj[k]) : AW'(r5_adj[k]);
            n6_word.neg[k] = r5_adj[k][AW-1] ^ dneg;
            n6_word.rem[k] = VW'(amag) << (2 * FRAC_BITS);
        end
    end

    assign o_valid = r_v[5];
    assign o_word  = r6_word;

endmodule

// ===== rtl/smi_divider.sv =====
`timescale 1ns / 1ps
// Back part, second half: pipelined restoring division of the nine adjugate entries.
module smi_divider (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  smi_pkg::t_div_word  i_word,
    output logic                o_valid,
    output smi_pkg::t_result    o_res
);
    import smi_pkg::*;

    t_div_word r_w [QW+1];
    logic      r_v [QW+1];
    t_div_word n_w [QW+1];
    t_div_word w_last;

    for (genvar g = 0; g <= QW; g++) begin : g_stage
        localparam int SH = (g == 0) ? QW : (QW - g);
        t_div_word stage_in;
        logic      stage_v;
        logic [VW-1:0] dsh;

        if (g == 0) begin : g_first
            assign stage_in = i_word;
            assign stage_v  = i_valid;
        end else begin : g_next
            assign stage_in = r_w[g-1];
            assign stage_v  = r_v[g-1];
        end

        assign dsh = stage_in.dmag << SH;

        if (g == 0) begin : g_ovf
            always_comb begin
                n_w[g] = stage_in;
                for (int k = 0; k < NE; k++) begin
                    n_w[g].ovf[k] = (stage_in.rem[k] >= dsh);
                end
            end
        end else begin : g_sub
            always_comb begin
                n_w[g] = stage_in;
                for (int k = 0; k < NE; k++) begin
                    if (stage_in.rem[k] >= dsh) begin
                        n_w[g].rem[k]    = stage_in.rem[k] - dsh;
                        n_w[g].q[k][SH]  = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= stage_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_w[g] <= n_w[g];
            end
        end
    end

    assign w_last  = r_w[QW];
    assign o_valid = r_v[QW];

    always_comb begin
        o_res.sing = w_last.sing;
        o_res.det  = w_last.sing ? '0 : w_last.det;
        for (int k = 0; k < NE; k++) begin
            o_res.inv[k] = w_last.sing ? '0 :
                           sat32(w_last.neg[k], w_last.ovf[k], w_last.q[k]);
        end
    end

endmodule
